// ===== design/stack_queue_opcode_engine_defines.svh =====
// Assertion macros shared by the stack/queue engine.
`ifndef STACK_QUEUE_OPCODE_ENGINE_DEFINES_SVH
`define STACK_QUEUE_OPCODE_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define SQOE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SQOE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sqoe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sqoe_pkg;

   localparam int DATA_W   = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PEEK = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SWAP = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ADD  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef logic signed [DATA_W-1:0] data_type;

   // what a cell loads this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_TAKE_UP,
      CELL_TAKE_DN,
      CELL_LOAD
   } cell_mode_type;

endpackage
`default_nettype wire

// ===== design/sqoe_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sqoe_req_if;
   import sqoe_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   data_type            push_value;

   modport source (output valid, output action, output push_value, input ready);
   modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface sqoe_rsp_if;
   import sqoe_pkg::*;

   logic                valid;
   logic                ready;
   data_type            top_value;
   logic                top_valid;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output top_value, output top_valid, output status,
                   input ready);
   modport sink   (input valid, input top_value, input top_valid, input status,
                   output ready);
endinterface
`default_nettype wire

// ===== design/sqoe_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sqoe_cell (
   input  wire                    clock,
   input  sqoe_pkg::cell_mode_type mode,
   input  sqoe_pkg::data_type     from_up,
   input  sqoe_pkg::data_type     from_dn,
   input  sqoe_pkg::data_type     load_data,
   output sqoe_pkg::data_type     value
);
   import sqoe_pkg::*;

   data_type value_ff;
   data_type value_in;

   always_comb begin
      unique case (mode)
         CELL_HOLD:    value_in = value_ff;
         CELL_TAKE_UP: value_in = from_up;
         CELL_TAKE_DN: value_in = from_dn;
         CELL_LOAD:    value_in = load_data;
         default:      value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ===== design/stack_queue_opcode_engine.sv =====
// Stack/queue opcode engine.
// req: one word per opcode (action, push_value), valid/ready handshake.
// rsp: one word per opcode (top_value, top_valid, status).
// csr: csr_we/csr_wdata write queue_mode (0 stack, 1 queue); write only when idle.
// Storage is a row of STORE_DEPTH cells; cell 0 always holds the top entry.
// Peek and errors hold all cells; others update cells together: cells shift toward
// or away from the top, the top two trade places, or the addressed cell loads.
// The response word is registered and is valid the cycle after the request is taken.
// Throughput: one opcode per cycle while rsp keeps up; the single output
// register limits it.
// Stall: while a response waits unread, req.ready is low; state holds.
// Reset: entry count, queue_mode and rsp.valid clear; cell contents are
// not cleared and are never shown before being written.
// Errors (empty, too short, full) leave the store unchanged and report status.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_queue_opcode_engine_defines.svh"
module stack_queue_opcode_engine #(
   parameter int STORE_DEPTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   sqoe_req_if.sink   req_if,
   sqoe_rsp_if.source rsp_if,
   input  wire        csr_we,
   input  wire        csr_wdata
);
   import sqoe_pkg::*;

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   logic             csr_queue_mode_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                rsp_valid_ff;
   data_type            rsp_top_value_ff;
   logic                rsp_top_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   data_type cell_value [STORE_DEPTH];
   data_type sum;
   data_type load_data;
   data_type top_in;

   logic                req_fire;
   logic                do_push_stk;
   logic                do_push_q;
   logic                do_pop;
   logic                do_swap;
   logic                do_add;
   logic [STATUS_W-1:0] status_in;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign sum          = cell_value[0] + cell_value[1];
   assign load_data    = do_add ? sum : req_if.push_value;

   always_comb begin
      do_push_stk = 1'b0;
      do_push_q   = 1'b0;
      do_pop      = 1'b0;
      do_swap     = 1'b0;
      do_add      = 1'b0;
      status_in   = ST_OK;
      count_in    = count_ff;
      top_in      = cell_value[0];
      unique case (req_if.action)
         ACT_PUSH: begin
            if (count_ff == CNT_W'(STORE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               if (csr_queue_mode_ff) begin
                  do_push_q = 1'b1;
                  if (count_ff == '0) begin
                     top_in = req_if.push_value;
                  end
               end else begin
                  do_push_stk = 1'b1;
                  top_in      = req_if.push_value;
               end
            end
         end
         ACT_PEEK: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end
         end
         ACT_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               do_pop   = 1'b1;
               count_in = count_ff - 1'b1;
               top_in   = cell_value[1];
            end
         end
         ACT_SWAP: begin
            if (count_ff < CNT_W'(2)) begin
               status_in = ST_SHORT;
            end else begin
               do_swap = 1'b1;
               top_in  = cell_value[1];
            end
         end
         ACT_ADD: begin
            if (count_ff < CNT_W'(2)) begin
               status_in = ST_SHORT;
            end else begin
               do_add   = 1'b1;
               count_in = count_ff - 1'b1;
               top_in   = sum;
            end
         end
         default: begin
         end
      endcase
   end

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      cell_mode_type mode;
      data_type      from_up;
      data_type      from_dn;

      if (i == 0) begin : g_first
         assign from_up = req_if.push_value;
      end else begin : g_up
         assign from_up = cell_value[i-1];
      end
      if (i == STORE_DEPTH - 1) begin : g_last
         assign from_dn = '0;
      end else begin : g_dn
         assign from_dn = cell_value[i+1];
      end

      always_comb begin
         mode = CELL_HOLD;
         if (req_fire) begin
            if (do_push_stk) begin
               mode = (i == 0) ? CELL_LOAD : CELL_TAKE_UP;
            end
            if (do_push_q && count_ff == CNT_W'(i)) begin
               mode = CELL_LOAD;
            end
            if (do_pop) begin
               mode = CELL_TAKE_DN;
            end
            if (do_swap && i == 0) begin
               mode = CELL_TAKE_DN;
            end
            if (do_swap && i == 1) begin
               mode = CELL_TAKE_UP;
            end
            if (do_add) begin
               mode = (i == 0) ? CELL_LOAD : CELL_TAKE_DN;
            end
         end
      end

      sqoe_cell u_cell (
         .clock     (clock),
         .mode      (mode),
         .from_up   (from_up),
         .from_dn   (from_dn),
         .load_data (load_data),
         .value     (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_queue_mode_ff <= 1'b0;
         count_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            csr_queue_mode_ff <= csr_wdata;
         end
         if (req_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_top_value_ff <= (count_in != '0) ? top_in : '0;
         rsp_top_valid_ff <= (count_in != '0);
         rsp_status_ff    <= status_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.top_value = rsp_top_value_ff;
   assign rsp_if.top_valid = rsp_top_valid_ff;
   assign rsp_if.status    = rsp_status_ff;

   `SQOE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(STORE_DEPTH), "entry count beyond depth")
   `SQOE_ASSERT_NEXT(a_rsp_follows, clock, reset, req_fire,
      rsp_valid_ff, "no response after request")
   `SQOE_ASSERT_NEXT(a_top_valid, clock, reset, req_fire,
      rsp_top_valid_ff == (count_ff != '0), "top_valid disagrees with count")
   `SQOE_ASSERT_NEXT(a_err_holds, clock, reset, req_fire && status_in != ST_OK,
      count_ff == $past(count_ff), "error changed count")

endmodule
`default_nettype wire
